// ----- rtl/mmwp_pkg.sv -----
`default_nettype none

package mmwp_pkg;

    // Fixed sizes of the datapath.
    localparam int WHEELS        = 4;
    localparam int FRAC_BITS_DEF = 16;
    localparam int TICK_FRAC     = 16;
    localparam int OP_W          = 35;
    localparam int PROD_W        = 2 * OP_W;
    localparam int NUM_W         = 66;
    localparam int DEN_W         = 34;
    localparam int CFG_IDX_W     = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_STICK_SCALE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INT_GAIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAS_GAIN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_COEF  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_BLEND  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_PERIOD  = 3'd7;

    localparam logic signed [PROD_W-1:0] S32_MAX = PROD_W'(64'sh7fffffff);
    localparam logic signed [PROD_W-1:0] S32_MIN = -S32_MAX - PROD_W'(1);

    // Saturate a wide signed value to signed 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] x);
        logic signed [31:0] y;
        if (x > S32_MAX)
        begin
            y = 32'sh7fffffff;
        end
        else if (x < S32_MIN)
        begin
            y = 32'sh80000000;
        end
        else
        begin
            y = x[31:0];
        end
        return y;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/mmwp_div.sv -----
`default_nettype none

module mmwp_div (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [mmwp_pkg::NUM_W-1:0] num,
    input  wire logic [mmwp_pkg::DEN_W-1:0] den,
    output logic                           done,
    output logic [mmwp_pkg::NUM_W-1:0]      quo
);
    import mmwp_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [DEN_W-1:0]     rem_reg, rem_next;
    logic [DEN_W-1:0]     den_reg, den_next;
    logic [NUM_W-1:0]     quo_reg, quo_next;
    logic [DEN_W:0]       shifted;
    logic [DEN_W:0]       trial;

    // One quotient bit per cycle, restoring form.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        shifted   = {rem_reg, quo_reg[NUM_W-1]};
        trial     = shifted - {1'b0, den_reg};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W);
            rem_next  = '0;
            den_next  = den;
            quo_next  = num;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, den_reg})
            begin
                rem_next = trial[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

`default_nettype wire

// ----- rtl/mecanum_mix_wheel_pid_top.sv -----
// Flow: each accepted item is mixed, then the four wheels are worked in turn through the
// bit-serial divider (up to three quotients per wheel: reference, feedback and error rate).
// The reference quotient is skipped when all wheel references are zero, the two rate
// quotients when the tick period is zero. No new item is taken while one is in work; the next
// item is taken once the result is registered.
// Reset: asynchronous, active low; control and configuration registers take their defaults
// and per-wheel state reads as zero until first written, through valid bits.
`default_nettype none

module mecanum_mix_wheel_pid_top #(
    parameter int FRAC_BITS = mmwp_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic signed [15:0]            stick_forward,
    input  wire logic signed [15:0]            stick_strafe,
    input  wire logic signed [15:0]            stick_rotate,
    input  wire logic signed [15:0]            wheel_speed_a,
    input  wire logic signed [15:0]            wheel_speed_b,
    input  wire logic signed [15:0]            wheel_speed_c,
    input  wire logic signed [15:0]            wheel_speed_d,
    input  wire logic                          stop,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic signed [15:0]                 drive_a,
    output logic signed [15:0]                 drive_b,
    output logic signed [15:0]                 drive_c,
    output logic signed [15:0]                 drive_d,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [mmwp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]                   cfg_data
);
    import mmwp_pkg::*;

    localparam int WH_W = $clog2(WHEELS);
    localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;
    localparam logic signed [33:0] INT_LIM = 34'sd50 <<< FRAC_BITS;

    typedef enum logic [23:0] {
        ST_IDLE = 24'h000001, ST_MF  = 24'h000002, ST_MS  = 24'h000004,
        ST_MR   = 24'h000008, ST_MX0 = 24'h000010, ST_MX1 = 24'h000020,
        ST_W0   = 24'h000040, ST_W1  = 24'h000080, ST_W2  = 24'h000100,
        ST_W3   = 24'h000200, ST_W4  = 24'h000400, ST_W5  = 24'h000800,
        ST_W6   = 24'h001000, ST_W7  = 24'h002000, ST_W8  = 24'h004000,
        ST_W9   = 24'h008000, ST_W10 = 24'h010000, ST_W11 = 24'h020000,
        ST_W12  = 24'h040000, ST_W13 = 24'h080000, ST_W14 = 24'h100000,
        ST_W15  = 24'h200000, ST_W16 = 24'h400000, ST_DONE = 24'h800000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [31:0] scale_reg, pg_reg, ig_reg, dg_reg, mg_reg;
    logic [16:0] coef_reg, blend_reg;
    logic [15:0] period_reg;
    logic [31:0] coef_c, blend_c, omb_c;

    // Captured item.
    logic signed [15:0] fwd_reg, str_reg, rot_reg;
    logic signed [15:0] spd_reg [WHEELS];
    logic               stop_reg;

    // Chassis values and mix.
    logic signed [31:0] f_reg, f_next, s_reg, s_next, r_reg, r_next;
    logic signed [33:0] w_reg [WHEELS];
    logic signed [33:0] w_c [WHEELS];
    logic [33:0]        mw_c [WHEELS];
    logic [33:0]        maxw_reg, maxw_c;
    logic [31:0]        maxcmd_reg, maxcmd_c, mf_c, ms_c, mr_c;
    logic               mix_en;

    // Per-wheel work registers.
    logic [WH_W-1:0]    wheel_reg, wheel_next;
    logic signed [32:0] ref_reg, ref_next;
    logic signed [31:0] pfb_reg, perr_reg, pint_reg, pfilt_reg;
    logic signed [31:0] fb_reg, fb_next, err_reg, err_next;
    logic signed [32:0] fbd_reg, fbd_next;
    logic signed [31:0] errd_reg, errd_next;
    logic signed [63:0] mterm_reg, mterm_next;
    logic signed [31:0] diff_reg, diff_next, isum_reg, isum_next;
    logic signed [31:0] filt_reg, filt_next, integ_reg, integ_next;
    logic signed [65:0] acc_reg, acc_next;
    logic signed [15:0] drv_reg [WHEELS];
    logic signed [15:0] drv_c;
    logic               drv_en, cap_en;

    // Shared multiplier.
    logic signed [OP_W-1:0]   mul_a, mul_b;
    logic signed [PROD_W-1:0] prod_reg, prod_fb, prod_t;

    // State memory: {prev_feedback, prev_error, error_integral, filtered_derivative}.
    logic [127:0]    mem [WHEELS];
    logic [127:0]    rd_data_reg;
    logic            rd_vld_reg;
    logic [WHEELS-1:0] vld_reg;
    logic            mem_rd, mem_wr;

    // Divider.
    logic             div_start, div_done;
    logic [NUM_W-1:0] div_num, div_quo;
    logic [DEN_W-1:0] div_den;
    logic             dneg_reg, dneg_next;

    // Output stage.
    logic               out_valid_reg, out_valid_next, out_load;
    logic signed [15:0] out_reg [WHEELS];

    // Helper signals.
    logic signed [31:0]       fb_c, err_c;
    logic signed [32:0]       d1_c, d2_c, cdiff_c;
    logic [32:0]              d1m_c, d2m_c;
    logic signed [PROD_W-1:0] qs_c;
    logic signed [33:0]       isum_acc_c;
    logic signed [65:0]       o_c, om_c, dq_c;
    logic signed [15:0]       spd_c;

    // Magnitude of a mixed wheel reference.
    function automatic logic [33:0] mw_c_sel(input logic signed [33:0] x);
        return x[33] ? 34'(-x) : 34'(x);
    endfunction

    mmwp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign drive_a   = out_reg[0];
    assign drive_b   = out_reg[1];
    assign drive_c   = out_reg[2];
    assign drive_d   = out_reg[3];

    // Coefficients above one are clamped to one.
    assign coef_c  = (32'(coef_reg) > ONE) ? ONE : 32'(coef_reg);
    assign blend_c = (32'(blend_reg) > ONE) ? ONE : 32'(blend_reg);
    assign omb_c   = ONE - blend_c;

    assign prod_fb = prod_reg >>> FRAC_BITS;
    assign prod_t  = prod_reg >>> TICK_FRAC;

    // Mix of the chassis references and the magnitudes for the rescale.
    always_comb
    begin
        w_c[0] = 34'(f_reg) + 34'(s_reg) + 34'(r_reg);
        w_c[1] = -34'(f_reg) + 34'(s_reg) + 34'(r_reg);
        w_c[2] = -34'(f_reg) - 34'(s_reg) + 34'(r_reg);
        w_c[3] = 34'(f_reg) - 34'(s_reg) + 34'(r_reg);
        for (int i = 0; i < WHEELS; i++)
        begin
            mw_c[i] = w_c[i][33] ? 34'(-w_c[i]) : 34'(w_c[i]);
        end
        mf_c = f_reg[31] ? 32'(-33'(f_reg)) : 32'(f_reg);
        ms_c = s_reg[31] ? 32'(-33'(s_reg)) : 32'(s_reg);
        mr_c = r_reg[31] ? 32'(-33'(r_reg)) : 32'(r_reg);
        maxcmd_c = mf_c;
        if (ms_c > maxcmd_c)
        begin
            maxcmd_c = ms_c;
        end
        if (mr_c > maxcmd_c)
        begin
            maxcmd_c = mr_c;
        end
        maxw_c = '0;
        for (int i = 0; i < WHEELS; i++)
        begin
            if (mw_c[i] > maxw_c)
            begin
                maxw_c = mw_c[i];
            end
        end
    end

    // Sequencer and datapath.
    always_comb
    begin
        state_next = state_reg;
        wheel_next = wheel_reg;
        f_next     = f_reg;
        s_next     = s_reg;
        r_next     = r_reg;
        ref_next   = ref_reg;
        fb_next    = fb_reg;
        err_next   = err_reg;
        fbd_next   = fbd_reg;
        errd_next  = errd_reg;
        mterm_next = mterm_reg;
        diff_next  = diff_reg;
        isum_next  = isum_reg;
        filt_next  = filt_reg;
        integ_next = integ_reg;
        acc_next   = acc_reg;
        dneg_next  = dneg_reg;
        mix_en     = 1'b0;
        cap_en     = 1'b0;
        drv_en     = 1'b0;
        mem_rd     = 1'b0;
        mem_wr     = 1'b0;
        out_load   = 1'b0;
        div_start  = 1'b0;
        div_num    = '0;
        div_den    = DEN_W'(period_reg);
        mul_a      = '0;
        mul_b      = '0;
        drv_c      = '0;

        spd_c  = spd_reg[wheel_reg];
        fb_c   = sat32(PROD_W'(spd_c) <<< FRAC_BITS);
        err_c  = sat32(PROD_W'(ref_reg) - PROD_W'(fb_c));
        d1_c   = 33'(fb_c) - 33'(pfb_reg);
        d1m_c  = d1_c[32] ? 33'(-d1_c) : 33'(d1_c);
        d2_c   = 33'(err_reg) - 33'(perr_reg);
        d2m_c  = d2_c[32] ? 33'(-d2_c) : 33'(d2_c);
        qs_c   = dneg_reg ? -PROD_W'(div_quo) : PROD_W'(div_quo);
        cdiff_c = 33'(diff_reg) - 33'(pfilt_reg);
        isum_acc_c = 34'(pint_reg) + 34'(prod_t);
        o_c    = acc_reg + 66'(prod_fb);
        om_c   = o_c[65] ? -o_c : o_c;
        dq_c   = om_c >>> FRAC_BITS;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_MF;
                end
            end
            ST_MF:
            begin
                mul_a = OP_W'(fwd_reg);
                mul_b = $signed({3'b000, scale_reg});
                state_next = ST_MS;
            end
            ST_MS:
            begin
                f_next = sat32(prod_reg);
                mul_a = OP_W'(str_reg);
                mul_b = $signed({3'b000, scale_reg});
                state_next = ST_MR;
            end
            ST_MR:
            begin
                s_next = sat32(prod_reg);
                mul_a = OP_W'(rot_reg);
                mul_b = $signed({3'b000, scale_reg});
                state_next = ST_MX0;
            end
            ST_MX0:
            begin
                r_next = sat32(prod_reg);
                state_next = ST_MX1;
            end
            ST_MX1:
            begin
                mix_en = 1'b1;
                wheel_next = '0;
                state_next = ST_W0;
            end
            // Read the wheel state and form |w| times the largest command.
            ST_W0:
            begin
                mem_rd = 1'b1;
                mul_a = $signed({1'b0, mw_c_sel(w_reg[wheel_reg])});
                mul_b = $signed({3'b000, maxcmd_reg});
                state_next = ST_W1;
            end
            ST_W1:
            begin
                cap_en = 1'b1;
                dneg_next = w_reg[wheel_reg][33];
                if (maxw_reg == '0)
                begin
                    ref_next = '0;
                    state_next = ST_W3;
                end
                else
                begin
                    div_start = 1'b1;
                    div_num = prod_reg[NUM_W-1:0];
                    div_den = maxw_reg;
                    state_next = ST_W2;
                end
            end
            ST_W2:
            begin
                if (div_done)
                begin
                    ref_next = dneg_reg ? -33'(div_quo[32:0]) : 33'(div_quo[32:0]);
                    state_next = ST_W3;
                end
            end
            // Feedback derivative.
            ST_W3:
            begin
                fb_next = fb_c;
                err_next = err_c;
                dneg_next = d1_c[32];
                if (period_reg == '0)
                begin
                    fbd_next = '0;
                    state_next = ST_W5;
                end
                else
                begin
                    div_start = 1'b1;
                    div_num = NUM_W'({d1m_c, 16'h0000});
                    state_next = ST_W4;
                end
            end
            ST_W4:
            begin
                if (div_done)
                begin
                    fbd_next = -33'(sat32(qs_c));
                    state_next = ST_W5;
                end
            end
            // Error derivative.
            ST_W5:
            begin
                dneg_next = d2_c[32];
                if (period_reg == '0)
                begin
                    errd_next = '0;
                    state_next = ST_W7;
                end
                else
                begin
                    div_start = 1'b1;
                    div_num = NUM_W'({d2m_c, 16'h0000});
                    state_next = ST_W6;
                end
            end
            ST_W6:
            begin
                if (div_done)
                begin
                    errd_next = sat32(qs_c);
                    state_next = ST_W7;
                end
            end
            ST_W7:
            begin
                mul_a = $signed({3'b000, mg_reg});
                mul_b = OP_W'(fbd_reg);
                state_next = ST_W8;
            end
            ST_W8:
            begin
                mterm_next = prod_fb[63:0];
                mul_a = $signed({3'b000, dg_reg});
                mul_b = OP_W'(errd_reg);
                state_next = ST_W9;
            end
            ST_W9:
            begin
                diff_next = sat32(prod_fb + PROD_W'(mterm_reg));
                isum_next = sat32(PROD_W'(err_reg) + PROD_W'(mterm_reg));
                state_next = ST_W10;
            end
            // Low-pass on the derivative sum.
            ST_W10:
            begin
                mul_a = $signed({3'b000, coef_c});
                mul_b = OP_W'(cdiff_c);
                state_next = ST_W11;
            end
            ST_W11:
            begin
                filt_next = sat32(PROD_W'(pfilt_reg) + prod_fb);
                mul_a = $signed({3'b000, 16'h0000, period_reg});
                mul_b = OP_W'(isum_reg);
                state_next = ST_W12;
            end
            // Clamped integral, then the output terms.
            ST_W12:
            begin
                if (isum_acc_c > INT_LIM)
                begin
                    integ_next = 32'(INT_LIM);
                end
                else if (isum_acc_c < -INT_LIM)
                begin
                    integ_next = 32'(-INT_LIM);
                end
                else
                begin
                    integ_next = isum_acc_c[31:0];
                end
                mul_a = $signed({3'b000, pg_reg});
                mul_b = OP_W'(err_reg);
                state_next = ST_W13;
            end
            ST_W13:
            begin
                acc_next = 66'(prod_fb);
                mul_a = $signed({3'b000, blend_c});
                mul_b = OP_W'(filt_reg);
                state_next = ST_W14;
            end
            ST_W14:
            begin
                acc_next = acc_reg + 66'(prod_fb);
                mul_a = $signed({3'b000, omb_c});
                mul_b = OP_W'(diff_reg);
                state_next = ST_W15;
            end
            ST_W15:
            begin
                acc_next = acc_reg + 66'(prod_fb);
                mul_a = $signed({3'b000, ig_reg});
                mul_b = OP_W'(integ_reg);
                state_next = ST_W16;
            end
            // Drive value, truncated toward zero and saturated (zero on stop); write state back.
            ST_W16:
            begin
                if (dq_c > 66'sd32767)
                begin
                    drv_c = o_c[65] ? -16'sd32767 - 16'sd1 : 16'sd32767;
                    if (o_c[65] && dq_c == 66'sd32768)
                    begin
                        drv_c = -16'sd32767 - 16'sd1;
                    end
                end
                else
                begin
                    drv_c = o_c[65] ? -dq_c[15:0] : dq_c[15:0];
                end
                if (stop_reg)
                begin
                    drv_c = '0;
                end
                drv_en = 1'b1;
                mem_wr = 1'b1;
                if (wheel_reg == WH_W'(WHEELS - 1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    wheel_next = wheel_reg + WH_W'(1);
                    state_next = ST_W0;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Control registers and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wheel_reg     <= '0;
            out_valid_reg <= 1'b0;
            vld_reg       <= '0;
            scale_reg     <= ONE;
            pg_reg        <= ONE;
            ig_reg        <= '0;
            dg_reg        <= '0;
            mg_reg        <= '0;
            coef_reg      <= '0;
            blend_reg     <= '0;
            period_reg    <= 16'd65;
        end
        else
        begin
            state_reg     <= state_next;
            wheel_reg     <= wheel_next;
            out_valid_reg <= out_valid_next;
            if (mem_wr)
            begin
                vld_reg[wheel_reg] <= 1'b1;
            end
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_STICK_SCALE: scale_reg  <= cfg_data;
                    CFG_PROP_GAIN:   pg_reg     <= cfg_data;
                    CFG_INT_GAIN:    ig_reg     <= cfg_data;
                    CFG_DERIV_GAIN:  dg_reg     <= cfg_data;
                    CFG_MEAS_GAIN:   mg_reg     <= cfg_data;
                    CFG_FILTER_COEF: coef_reg   <= cfg_data[16:0];
                    CFG_DERIV_BLEND: blend_reg  <= cfg_data[16:0];
                    CFG_TICK_PERIOD: period_reg <= cfg_data[15:0];
                    default:         ;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        prod_reg  <= mul_a * mul_b;
        f_reg     <= f_next;
        s_reg     <= s_next;
        r_reg     <= r_next;
        ref_reg   <= ref_next;
        fb_reg    <= fb_next;
        err_reg   <= err_next;
        fbd_reg   <= fbd_next;
        errd_reg  <= errd_next;
        mterm_reg <= mterm_next;
        diff_reg  <= diff_next;
        isum_reg  <= isum_next;
        filt_reg  <= filt_next;
        integ_reg <= integ_next;
        acc_reg   <= acc_next;
        dneg_reg  <= dneg_next;
        if (state_reg == ST_IDLE && in_valid)
        begin
            fwd_reg    <= stick_forward;
            str_reg    <= stick_strafe;
            rot_reg    <= stick_rotate;
            spd_reg[0] <= wheel_speed_a;
            spd_reg[1] <= wheel_speed_b;
            spd_reg[2] <= wheel_speed_c;
            spd_reg[3] <= wheel_speed_d;
            stop_reg   <= stop;
        end
        if (mix_en)
        begin
            for (int i = 0; i < WHEELS; i++)
            begin
                w_reg[i] <= w_c[i];
            end
            maxw_reg   <= maxw_c;
            maxcmd_reg <= maxcmd_c;
        end
        if (cap_en)
        begin
            pfb_reg   <= rd_vld_reg ? rd_data_reg[127:96] : '0;
            perr_reg  <= rd_vld_reg ? rd_data_reg[95:64] : '0;
            pint_reg  <= rd_vld_reg ? rd_data_reg[63:32] : '0;
            pfilt_reg <= rd_vld_reg ? rd_data_reg[31:0] : '0;
        end
        if (drv_en)
        begin
            drv_reg[wheel_reg] <= drv_c;
        end
        if (out_load)
        begin
            for (int i = 0; i < WHEELS; i++)
            begin
                out_reg[i] <= drv_reg[i];
            end
        end
    end

    // Wheel state memory, registered read.
    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            mem[wheel_reg] <= {fb_reg, err_reg, integ_reg, filt_reg};
        end
        if (mem_rd)
        begin
            rd_data_reg <= mem[wheel_reg];
            rd_vld_reg  <= vld_reg[wheel_reg];
        end
    end

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
`default_nettype none

module tb_top;
    import mmwp_pkg::*;

    localparam int NWH = 4;
    localparam int FB = 16;
    localparam longint ONE_FX = 64'sd1 << FB;
    localparam longint INT_LIM = 64'sd50 << FB;

    // One tick of stimulus.
    typedef struct packed {
        logic signed [15:0] fwd;
        logic signed [15:0] strafe;
        logic signed [15:0] rot;
        logic signed [15:0] spd_a;
        logic signed [15:0] spd_b;
        logic signed [15:0] spd_c;
        logic signed [15:0] spd_d;
        logic               halt;
    } tick_t;

    // Four wheel drives.
    typedef struct packed {
        logic signed [15:0] da;
        logic signed [15:0] db;
        logic signed [15:0] dc;
        logic signed [15:0] dd;
    } drives_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic signed [15:0] stick_forward, stick_strafe, stick_rotate;
    logic signed [15:0] wheel_speed_a, wheel_speed_b, wheel_speed_c, wheel_speed_d;
    logic stop;
    logic out_valid;
    logic out_stall;
    logic signed [15:0] drive_a, drive_b, drive_c, drive_d;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0] cfg_data;

    mecanum_mix_wheel_pid_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .stick_forward(stick_forward), .stick_strafe(stick_strafe),
        .stick_rotate(stick_rotate),
        .wheel_speed_a(wheel_speed_a), .wheel_speed_b(wheel_speed_b),
        .wheel_speed_c(wheel_speed_c), .wheel_speed_d(wheel_speed_d),
        .stop(stop),
        .out_valid(out_valid), .out_stall(out_stall),
        .drive_a(drive_a), .drive_b(drive_b), .drive_c(drive_c), .drive_d(drive_d),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Clock generation.
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Shadow copy of the configuration and the per-wheel loop state.
    logic [31:0] m_scale, m_kp, m_ki, m_kd, m_kmd;
    logic [16:0] m_coef, m_blend;
    logic [15:0] m_period;
    longint st_fb[NWH], st_err[NWH], st_integ[NWH], st_filt[NWH];

    tick_t   pending_ticks[$];
    drives_t expected_drives[$];
    int      error_count;
    int      send_idle_pct, recv_idle_pct;
    int      hold_cycles;
    bit      hold_go;
    bit      hold_used;

    function automatic longint clip32(longint x);
        if (x > 64'sd2147483647)
        begin
            return 64'sd2147483647;
        end
        if (x < -64'sd2147483648)
        begin
            return -64'sd2147483648;
        end
        return x;
    endfunction

    // Floor shift of a signed value; the product may exceed 64 bits, so work at 128.
    function automatic longint floor_shr(logic signed [127:0] x, int n);
        logic signed [127:0] y;
        y = x >>> n;
        return longint'(y);
    endfunction

    function automatic longint gain_mul(logic [31:0] g, longint v);
        logic signed [127:0] p;
        p = $signed({96'd0, g}) * 128'(v);
        return floor_shr(p, FB);
    endfunction

    function automatic longint rate_of(longint d);
        if (m_period == 16'd0)
        begin
            return 0;
        end
        return clip32((d * 65536) / longint'({48'd0, m_period}));
    endfunction

    function automatic longint absval(longint x);
        return (x < 0) ? -x : x;
    endfunction

    // Mix the sticks, run the four wheel loops and return the drives.
    function automatic drives_t predict_drives(tick_t t);
        longint f, s, r, maxcmd, maxw, coef, blend;
        longint w[NWH];
        longint meas[NWH];
        longint wref, fbv, fbd, err, errd, mterm, diff, filt, isum, integ, o, d;
        logic [63:0] q;
        logic signed [15:0] res[NWH];
        drives_t out;
        f = clip32(longint'(t.fwd) * longint'({32'd0, m_scale}));
        s = clip32(longint'(t.strafe) * longint'({32'd0, m_scale}));
        r = clip32(longint'(t.rot) * longint'({32'd0, m_scale}));
        coef = (m_coef > 17'd65536) ? ONE_FX : longint'({47'd0, m_coef});
        blend = (m_blend > 17'd65536) ? ONE_FX : longint'({47'd0, m_blend});
        w[0] = f + s + r;
        w[1] = -f + s + r;
        w[2] = -f - s + r;
        w[3] = f - s + r;
        meas[0] = t.spd_a;
        meas[1] = t.spd_b;
        meas[2] = t.spd_c;
        meas[3] = t.spd_d;
        maxcmd = absval(f);
        if (absval(s) > maxcmd) maxcmd = absval(s);
        if (absval(r) > maxcmd) maxcmd = absval(r);
        maxw = 0;
        for (int i = 0; i < NWH; i++)
        begin
            if (absval(w[i]) > maxw) maxw = absval(w[i]);
        end
        for (int i = 0; i < NWH; i++)
        begin
            wref = 0;
            if (maxw != 0)
            begin
                // The product can pass 2^63, so the division is unsigned.
                q = ($unsigned(absval(w[i])) * $unsigned(maxcmd)) / $unsigned(maxw);
                wref = (w[i] < 0) ? -longint'(q) : longint'(q);
            end
            fbv = clip32(meas[i] * ONE_FX);
            fbd = -rate_of(fbv - st_fb[i]);
            err = clip32(wref - fbv);
            errd = rate_of(err - st_err[i]);
            mterm = gain_mul(m_kmd, fbd);
            diff = clip32(gain_mul(m_kd, errd) + mterm);
            filt = st_filt[i];
            filt = clip32(filt + floor_shr(128'(coef * (diff - filt)), FB));
            isum = clip32(err + mterm);
            integ = st_integ[i] + floor_shr(128'(isum * longint'({48'd0, m_period})), 16);
            if (integ > INT_LIM) integ = INT_LIM;
            if (integ < -INT_LIM) integ = -INT_LIM;
            o = gain_mul(m_kp, err) + floor_shr(128'(blend * filt), FB)
                + floor_shr(128'((ONE_FX - blend) * diff), FB) + gain_mul(m_ki, integ);
            d = (o >= 0) ? (o >>> FB) : -((-o) >>> FB);
            if (d > 32767) d = 32767;
            if (d < -32768) d = -32768;
            if (t.halt) d = 0;
            res[i] = 16'(d);
            st_filt[i] = filt;
            st_integ[i] = integ;
            st_fb[i] = fbv;
            st_err[i] = err;
        end
        out.da = res[0];
        out.db = res[1];
        out.dc = res[2];
        out.dd = res[3];
        return out;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    // Driver: offers queued items, holds a stalled item steady.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_drives.push_back(predict_drives({stick_forward, stick_strafe,
                    stick_rotate, wheel_speed_a, wheel_speed_b, wheel_speed_c,
                    wheel_speed_d, stop}));
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_ticks.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    tick_t t;
                    t = pending_ticks.pop_front();
                    in_valid <= 1'b1;
                    stick_forward <= t.fwd;
                    stick_strafe <= t.strafe;
                    stick_rotate <= t.rot;
                    wheel_speed_a <= t.spd_a;
                    wheel_speed_b <= t.spd_b;
                    wheel_speed_c <= t.spd_c;
                    wheel_speed_d <= t.spd_d;
                    stop <= t.halt;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver back-pressure; a requested long hold-off is counted down here.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall   <= 1'b0;
            hold_cycles <= 0;
            hold_used   <= 1'b0;
        end
        else
        begin
            if (hold_go && !hold_used)
            begin
                hold_cycles <= 3000;
                hold_used   <= 1'b1;
            end
            else if (hold_cycles > 0)
            begin
                hold_cycles <= hold_cycles - 1;
            end
            out_stall <= (hold_cycles > 0) || ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Monitor: checks each accepted result against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_drives.size() == 0)
            begin
                $display("unexpected result item");
                error_count++;
            end
            else
            begin
                drives_t e;
                e = expected_drives.pop_front();
                if (drive_a !== e.da) report_mismatch("drive_a", drive_a, e.da);
                if (drive_b !== e.db) report_mismatch("drive_b", drive_b, e.db);
                if (drive_c !== e.dc) report_mismatch("drive_c", drive_c, e.dc);
                if (drive_d !== e.dd) report_mismatch("drive_d", drive_d, e.dd);
            end
        end
    end

    // Register write over the configuration channel; model copy updated too.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_STICK_SCALE: m_scale = val;
            CFG_PROP_GAIN:   m_kp = val;
            CFG_INT_GAIN:    m_ki = val;
            CFG_DERIV_GAIN:  m_kd = val;
            CFG_MEAS_GAIN:   m_kmd = val;
            CFG_FILTER_COEF: m_coef = val[16:0];
            CFG_DERIV_BLEND: m_blend = val[16:0];
            default:         m_period = val[15:0];
        endcase
    endtask

    // Wait for the queues to drain, then a little longer.
    task automatic drain();
        while (pending_ticks.size() > 0 || in_valid || expected_drives.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic signed [15:0] rnd16();
        case ($urandom_range(9))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'sd0;
            3, 4: return 16'($signed($urandom_range(200)) - 100);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic tick_t rnd_tick();
        tick_t t;
        t.fwd = rnd16();
        t.strafe = rnd16();
        t.rot = rnd16();
        t.spd_a = rnd16();
        t.spd_b = rnd16();
        t.spd_c = rnd16();
        t.spd_d = rnd16();
        t.halt = ($urandom_range(9) == 0);
        return t;
    endfunction

    task automatic random_config();
        write_reg(CFG_STICK_SCALE, ($urandom_range(3) == 0) ? $urandom
                  : $urandom_range(32'h0003_0000));
        write_reg(CFG_PROP_GAIN, ($urandom_range(4) == 0) ? $urandom
                  : $urandom_range(32'h0004_0000));
        write_reg(CFG_INT_GAIN, $urandom_range(32'h0002_0000));
        write_reg(CFG_DERIV_GAIN, $urandom_range(32'h0000_4000));
        write_reg(CFG_MEAS_GAIN, $urandom_range(32'h0000_4000));
        write_reg(CFG_FILTER_COEF, $urandom_range(17'h1ffff));
        write_reg(CFG_DERIV_BLEND, $urandom_range(17'h1ffff));
        write_reg(CFG_TICK_PERIOD, ($urandom_range(5) == 0) ? 32'd0 : $urandom_range(16'hffff));
    endtask

    // Main sequence.
    initial
    begin
        tick_t t;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        {stick_forward, stick_strafe, stick_rotate} = '0;
        {wheel_speed_a, wheel_speed_b, wheel_speed_c, wheel_speed_d} = '0;
        stop = 1'b0;
        m_scale = 32'h0001_0000;
        m_kp = 32'h0001_0000;
        m_ki = '0;
        m_kd = '0;
        m_kmd = '0;
        m_coef = '0;
        m_blend = '0;
        m_period = 16'd65;
        for (int i = 0; i < NWH; i++)
        begin
            st_fb[i] = 0;
            st_err[i] = 0;
            st_integ[i] = 0;
            st_filt[i] = 0;
        end
        error_count = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_go = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: defaults, zero sticks, extremes, stop.
        pending_ticks.push_back('0);
        pending_ticks.push_back({16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000,
                                 16'sh7fff, 16'sh8000, 16'sh7fff, 1'b0});
        pending_ticks.push_back({16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff,
                                 16'sh8000, 16'sh7fff, 16'sh8000, 1'b0});
        pending_ticks.push_back({16'sd100, -16'sd100, 16'sd0, 16'sd5, -16'sd5,
                                 16'sd0, 16'sd1, 1'b1});
        pending_ticks.push_back({16'sd0, 16'sd0, 16'sd0, 16'sd300, 16'sd300,
                                 -16'sd300, -16'sd300, 1'b0});
        drain();

        // Large gains, coefficients above one, zero period.
        write_reg(CFG_STICK_SCALE, 32'hffff_ffff);
        write_reg(CFG_PROP_GAIN, 32'hffff_ffff);
        write_reg(CFG_INT_GAIN, 32'hffff_ffff);
        write_reg(CFG_DERIV_GAIN, 32'hffff_ffff);
        write_reg(CFG_MEAS_GAIN, 32'hffff_ffff);
        write_reg(CFG_FILTER_COEF, 32'h0001_ffff);
        write_reg(CFG_DERIV_BLEND, 32'h0001_ffff);
        write_reg(CFG_TICK_PERIOD, 32'h0000_ffff);
        for (int i = 0; i < 6; i++) pending_ticks.push_back(rnd_tick());
        drain();
        write_reg(CFG_TICK_PERIOD, 32'd0);
        write_reg(CFG_FILTER_COEF, 32'h0001_0000);
        write_reg(CFG_DERIV_BLEND, 32'h0000_8000);
        write_reg(CFG_STICK_SCALE, 32'd0);
        for (int i = 0; i < 6; i++) pending_ticks.push_back(rnd_tick());
        drain();
        write_reg(CFG_TICK_PERIOD, 32'd1);
        write_reg(CFG_STICK_SCALE, 32'd1);
        for (int i = 0; i < 6; i++) pending_ticks.push_back(rnd_tick());
        drain();

        // Random phases with differing idle shares and settings.
        for (int ph = 0; ph < 6; ph++)
        begin
            random_config();
            send_idle_pct = (ph % 3 == 0) ? 34 : (ph % 3 == 1) ? 46 : 0;
            recv_idle_pct = (ph % 3 == 0) ? 46 : (ph % 3 == 1) ? 34 : 0;
            for (int i = 0; i < 170; i++) pending_ticks.push_back(rnd_tick());
            if (ph == 1)
            begin
                // Long receiver hold-off while items keep coming.
                hold_go = 1'b1;
                wait (hold_used && hold_cycles == 0);
                hold_go = 1'b0;
            end
            drain();
        end
        if (error_count == 0)
        begin
            $display("tb_top: done, clean");
        end
        else
        begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

    // Watchdog.
    initial
    begin
        #60000000;
        $display("tb_top: done, errors");
        $finish;
    end

endmodule

`default_nettype wire

// ----- mecanum_mix_wheel_pid_top.f -----
rtl/mmwp_pkg.sv
rtl/mmwp_div.sv
rtl/mecanum_mix_wheel_pid_top.sv
bench/tb_top.sv
